FILE: sv/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types and constants shared by the discharge power controller modules.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned PowerW  = 12;
  localparam int unsigned ChargeW = 7;
  localparam int unsigned GridW   = 16;
  localparam int unsigned CurW    = 15;
  localparam int unsigned ExtW    = 13;
  localparam int unsigned FrameW  = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POWER_LIMIT = 2'd0,
    REG_NIGHT_POWER = 2'd1,
    REG_SOC_MIN     = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    COND_MODE     = 3'd0,
    COND_LOW_SOC  = 3'd1,
    COND_CHARGING = 3'd2,
    COND_EXTERNAL = 3'd3,
    COND_FEEDING  = 3'd4,
    COND_BUYING   = 3'd5,
    COND_DEFAULT  = 3'd6
  } cond_e;

  localparam logic [2:0] ModeNormal = 3'd0;

  localparam logic [PowerW-1:0]  PowerLimitRst = 12'd600;
  localparam logic [PowerW-1:0]  NightPowerRst = 12'd200;
  localparam logic [ChargeW-1:0] SocMinRst     = 7'd20;
  localparam logic [GridW-1:0]   HeldGridRst   = 16'd0;
  localparam logic [ChargeW-1:0] HeldChargeRst = 7'd50;

  localparam logic signed [CurW-1:0]  CurLimit  = 15'sd200;
  localparam logic signed [GridW-1:0] FeedLimit = 16'sd200;
  localparam logic signed [GridW-1:0] BuyLimit  = -16'sd100;
  localparam logic [PowerW-1:0]       DayPower  = 12'd10;

  // floor(m/100) = (m * Recip100) >> Recip100Sh, exact for m < 4096
  localparam logic [12:0]     Recip100   = 13'd5243;
  localparam int unsigned     Recip100Sh = 19;

  localparam logic [7:0] FrameB0      = 8'h24;
  localparam logic [7:0] FrameB1      = 8'h56;
  localparam logic [7:0] FrameB2      = 8'h00;
  localparam logic [7:0] FrameB3      = 8'h21;
  localparam logic [7:0] FrameB6      = 8'h80;
  localparam logic [8:0] FrameSumBase = 9'd264;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthDec = 4'd12;

  typedef struct packed {
    logic                     record_ok;
    logic signed [GridW-1:0]  grid_power;
    logic                     grid_valid;
    logic [ChargeW-1:0]       charge_percent;
    logic signed [CurW-1:0]   battery_current;
    logic                     current_valid;
    logic [2:0]               inverter_mode;
    logic                     mode_valid;
    logic signed [ExtW-1:0]   external_setpoint;
    logic                     night_window;
    logic [3:0]               month;
    logic [15:0]              heat_pump_power;
  } item_t;

  typedef struct packed {
    logic [PowerW-1:0]  power_limit;
    logic [PowerW-1:0]  night_power;
    logic [ChargeW-1:0] soc_min;
  } cfg_t;

  typedef struct packed {
    logic signed [GridW-1:0] grid;
    logic [ChargeW-1:0]      charge;
  } held_t;

  typedef struct packed {
    logic                    upd_grid;
    logic                    upd_charge;
    logic signed [GridW-1:0] grid;
    logic [ChargeW-1:0]      charge;
  } held_upd_t;

  typedef struct packed {
    logic [PowerW-1:0] power;
    cond_e             cond;
  } decision_t;

endpackage

FILE: sv/bdpc_decide.sv
// ----------------------------------------------------------------------------
// bdpc_decide
// Priority decision of the discharge setpoint and update of the held readings.
// ----------------------------------------------------------------------------
module bdpc_decide (
  input  bdpc_pkg::item_t     item_i,
  input  bdpc_pkg::cfg_t      cfg_i,
  input  bdpc_pkg::held_t     held_i,
  output bdpc_pkg::decision_t dec_o,
  output bdpc_pkg::held_upd_t upd_o
);

  logic                                g_ok;
  logic                                c_ok;
  logic                                m_ok;
  logic [bdpc_pkg::ChargeW-1:0]        charge;
  logic signed [bdpc_pkg::GridW-1:0]   g;
  logic [bdpc_pkg::GridW:0]            mag;
  logic                                mag_big;
  logic [24:0]                         prod;
  logic [5:0]                          hundredths;
  logic [12:0]                         buy_base;
  logic [13:0]                         buy_sum;
  logic [bdpc_pkg::PowerW-1:0]         buy_power;
  logic                                ext_ok;
  logic                                winter;
  logic [bdpc_pkg::PowerW-1:0]         power;
  bdpc_pkg::cond_e                     cond;

  assign g_ok   = item_i.record_ok & item_i.grid_valid;
  assign c_ok   = item_i.record_ok & item_i.current_valid;
  assign m_ok   = item_i.record_ok & item_i.mode_valid;
  assign charge = item_i.record_ok ? item_i.charge_percent : held_i.charge;
  assign g      = g_ok ? item_i.grid_power : held_i.grid;

  // magnitude of a buying reading, saturated once it surely exceeds any limit
  assign mag        = (bdpc_pkg::GridW+1)'(-$signed({g[bdpc_pkg::GridW-1], g}));
  assign mag_big    = |mag[bdpc_pkg::GridW:12];
  assign prod       = 25'(mag[11:0]) * 25'(bdpc_pkg::Recip100);
  assign hundredths = prod[24:bdpc_pkg::Recip100Sh];
  assign buy_base   = mag_big ? 13'h1fff : (13'(mag[11:0]) + 13'(hundredths));
  assign buy_sum    = 14'(buy_base) +
                      (item_i.night_window ? 14'(cfg_i.night_power) : 14'd0);
  assign buy_power  = (buy_sum > 14'(cfg_i.power_limit)) ? cfg_i.power_limit
                                                         : buy_sum[bdpc_pkg::PowerW-1:0];

  assign ext_ok = ~item_i.external_setpoint[bdpc_pkg::ExtW-1] &&
                  (item_i.external_setpoint[bdpc_pkg::PowerW-1:0] <= cfg_i.power_limit);

  assign winter = ((item_i.month >= bdpc_pkg::MonthSep) && (item_i.month <= bdpc_pkg::MonthDec))
                  || (item_i.month == bdpc_pkg::MonthJan) || (item_i.month == bdpc_pkg::MonthFeb);

  always_comb begin
    power = '0;
    cond  = bdpc_pkg::COND_DEFAULT;
    if (m_ok && (item_i.inverter_mode != bdpc_pkg::ModeNormal)) begin
      cond = bdpc_pkg::COND_MODE;
    end else if (charge < cfg_i.soc_min) begin
      cond = bdpc_pkg::COND_LOW_SOC;
    end else if (c_ok && (item_i.battery_current > bdpc_pkg::CurLimit)) begin
      cond = bdpc_pkg::COND_CHARGING;
    end else if (ext_ok) begin
      cond  = bdpc_pkg::COND_EXTERNAL;
      power = item_i.external_setpoint[bdpc_pkg::PowerW-1:0];
    end else if (g > bdpc_pkg::FeedLimit) begin
      cond = bdpc_pkg::COND_FEEDING;
    end else if (g < bdpc_pkg::BuyLimit) begin
      cond  = bdpc_pkg::COND_BUYING;
      power = buy_power;
    end else begin
      cond  = bdpc_pkg::COND_DEFAULT;
      power = item_i.night_window ? cfg_i.night_power : bdpc_pkg::DayPower;
    end
    // heat pump cap in winter
    if (((cond == bdpc_pkg::COND_BUYING) || (cond == bdpc_pkg::COND_DEFAULT)) && winter &&
        (item_i.heat_pump_power > 16'(cfg_i.night_power))) begin
      if (cond == bdpc_pkg::COND_DEFAULT) begin
        power = cfg_i.night_power;
      end else if (power > cfg_i.night_power) begin
        power = cfg_i.night_power;
      end
    end
    if (power > cfg_i.power_limit) begin
      power = cfg_i.power_limit;
    end
  end

  assign dec_o.power = power;
  assign dec_o.cond  = cond;

  assign upd_o.upd_grid   = (cond != bdpc_pkg::COND_MODE) && g_ok;
  assign upd_o.upd_charge = (cond != bdpc_pkg::COND_MODE);
  assign upd_o.grid       = item_i.grid_power;
  assign upd_o.charge     = charge;

endmodule

FILE: sv/bdpc_frame.sv
// ----------------------------------------------------------------------------
// bdpc_frame
// Builds the 8-byte inverter command frame with its checksum byte.
// ----------------------------------------------------------------------------
module bdpc_frame (
  input  logic [bdpc_pkg::PowerW-1:0] power_i,
  output logic [bdpc_pkg::FrameW-1:0] frame_o
);

  logic [7:0] hi;
  logic [7:0] lo;
  logic [8:0] sum;

  assign hi  = 8'(power_i[bdpc_pkg::PowerW-1:8]);
  assign lo  = power_i[7:0];
  assign sum = bdpc_pkg::FrameSumBase - {1'b0, hi} - {1'b0, lo};

  assign frame_o = {bdpc_pkg::FrameB0, bdpc_pkg::FrameB1, bdpc_pkg::FrameB2,
                    bdpc_pkg::FrameB3, hi, lo, bdpc_pkg::FrameB6, sum[7:0]};

endmodule

FILE: sv/battery_discharge_power_controller.sv
// ----------------------------------------------------------------------------
// battery_discharge_power_controller
// Control tick in, discharge setpoint, condition and command frame out.
// ----------------------------------------------------------------------------
// Each request is registered on entry, decided combinationally and registered
// again on the result side, so a result is offered once its request has
// reached the result register, and a new request is taken every cycle while
// results are drained. The held grid power and charge are updated as a request
// moves into the result register, so the next request always sees them.
// Configuration writes take effect at once and are meant for idle periods.
module battery_discharge_power_controller (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxW-1:0]             cfg_idx_i,
  input  logic [bdpc_pkg::PowerW-1:0]              cfg_data_i,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // record_ok, grid_power, grid_valid, charge_percent, battery_current,
  // current_valid, inverter_mode, mode_valid, external_setpoint, night_window,
  // month, heat_pump_power
  input  logic [bdpc_pkg::InDataW-1:0]             s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // power_setpoint, condition, command_frame
  output logic [bdpc_pkg::OutDataW-1:0]            m_axis_tdata
);

  bdpc_pkg::cfg_t      cfg_q;
  bdpc_pkg::held_t     held_q;
  bdpc_pkg::item_t     item_d;
  bdpc_pkg::item_t     item_q;
  logic                item_vld_q;
  bdpc_pkg::decision_t dec;
  bdpc_pkg::held_upd_t upd;
  logic [bdpc_pkg::FrameW-1:0] frame;
  logic [bdpc_pkg::OutDataW-1:0] res_d;
  logic [bdpc_pkg::OutDataW-1:0] res_q;
  logic                res_vld_q;
  logic                advance;
  logic                in_acc;

  assign advance       = item_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !item_vld_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign item_d.record_ok         = s_axis_tdata[0];
  assign item_d.grid_power        = s_axis_tdata[16:1];
  assign item_d.grid_valid        = s_axis_tdata[17];
  assign item_d.charge_percent    = s_axis_tdata[24:18];
  assign item_d.battery_current   = s_axis_tdata[39:25];
  assign item_d.current_valid     = s_axis_tdata[40];
  assign item_d.inverter_mode     = s_axis_tdata[43:41];
  assign item_d.mode_valid        = s_axis_tdata[44];
  assign item_d.external_setpoint = s_axis_tdata[57:45];
  assign item_d.night_window      = s_axis_tdata[58];
  assign item_d.month             = s_axis_tdata[62:59];
  assign item_d.heat_pump_power   = s_axis_tdata[78:63];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_limit <= bdpc_pkg::PowerLimitRst;
      cfg_q.night_power <= bdpc_pkg::NightPowerRst;
      cfg_q.soc_min     <= bdpc_pkg::SocMinRst;
    end else if (cfg_we_i) begin
      case (bdpc_pkg::reg_idx_e'(cfg_idx_i))
        bdpc_pkg::REG_POWER_LIMIT: cfg_q.power_limit <= cfg_data_i;
        bdpc_pkg::REG_NIGHT_POWER: cfg_q.night_power <= cfg_data_i;
        bdpc_pkg::REG_SOC_MIN:     cfg_q.soc_min     <= cfg_data_i[bdpc_pkg::ChargeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= item_d;
    end
  end

  bdpc_decide u_decide (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .held_i (held_q),
    .dec_o  (dec),
    .upd_o  (upd)
  );

  bdpc_frame u_frame (
    .power_i (dec.power),
    .frame_o (frame)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q.grid   <= bdpc_pkg::HeldGridRst;
      held_q.charge <= bdpc_pkg::HeldChargeRst;
    end else if (advance) begin
      if (upd.upd_grid) begin
        held_q.grid <= upd.grid;
      end
      if (upd.upd_charge) begin
        held_q.charge <= upd.charge;
      end
    end
  end

  assign res_d = {1'b0, frame, dec.cond, dec.power};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = res_q;

endmodule
